@@ rtl/bagap_pkg.sv @@
package bagap_pkg;

  localparam int unsigned MaxContoursDef = 64;
  localparam int unsigned CoordBitsDef   = 12;
  localparam int unsigned ScaleW         = 10;
  localparam int unsigned FracW          = 16;
  localparam int unsigned ScoreW         = 26;
  localparam int unsigned OutAreaW       = 25;
  localparam int unsigned OutIdxW        = 6;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(1);

  typedef enum logic [1:0] {
    SEL_I,
    SEL_J,
    SEL_RANK
  } score_sel_e;

  typedef struct packed {
    logic       accept;
    logic       mm_upd;
    logic       mm_first;
    logic       sc_load;
    logic       div_step;
    logic       sc_write;
    logic       rk_load;
    logic       rk_cmp;
    logic       j_lt_i;
    logic       rk_write;
    logic       area_sel_rank;
    score_sel_e score_sel;
    logic       sp_upd;
    logic       first_pos;
    logic       emit;
    logic       last;
    logic       set_done;
  } cmd_t;

endpackage

@@ rtl/bagap_ram.sv @@
module bagap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bagap_ctrl.sv @@
module bagap_ctrl
  import bagap_pkg::*;
#(
  parameter int unsigned MaxContours = MaxContoursDef,
  parameter int unsigned DivSteps    = ScaleW + 2 * CoordBitsDef + 1 + FracW,
  localparam int unsigned IdxW  = $clog2(MaxContours),
  localparam int unsigned CntW  = $clog2(MaxContours + 1),
  localparam int unsigned StepW = $clog2(DivSteps)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            set_end_i,
  input  logic [CntW-1:0] count_i,
  output logic            busy_o,
  output cmd_t            cmd_o,
  output logic [IdxW-1:0] idx_i_o,
  output logic [IdxW-1:0] idx_j_o
);

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_MM_ADDR,
    ST_MM_DATA,
    ST_SC_ADDR,
    ST_SC_LOAD,
    ST_SC_DIV,
    ST_SC_WRITE,
    ST_RK_ADDR_I,
    ST_RK_LOAD_I,
    ST_RK_ADDR_J,
    ST_RK_CMP,
    ST_RK_WRITE,
    ST_FT_RANK,
    ST_FT_DATA,
    ST_FT_USE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  i_q;
  logic [CntW-1:0]  j_q;
  logic [StepW-1:0] step_q;
  logic             phase_q;
  logic             i_last;
  logic             j_last;

  assign i_last  = (i_q + CntW'(1)) == count_i;
  assign j_last  = (j_q + CntW'(1)) == count_i;
  assign idx_i_o = i_q[IdxW-1:0];
  assign idx_j_o = j_q[IdxW-1:0];
  assign busy_o  = (state_q != ST_COLLECT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      i_q     <= '0;
      j_q     <= '0;
      step_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_COLLECT: begin
          if (start_i && set_end_i) begin
            i_q     <= '0;
            state_q <= ST_MM_ADDR;
          end
        end
        ST_MM_ADDR: state_q <= ST_MM_DATA;
        ST_MM_DATA: begin
          if (i_last) begin
            i_q     <= '0;
            state_q <= ST_SC_ADDR;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= ST_MM_ADDR;
          end
        end
        ST_SC_ADDR: state_q <= ST_SC_LOAD;
        ST_SC_LOAD: begin
          step_q  <= '0;
          state_q <= ST_SC_DIV;
        end
        ST_SC_DIV: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= ST_SC_WRITE;
          end
        end
        ST_SC_WRITE: begin
          if (i_last) begin
            i_q     <= '0;
            state_q <= ST_RK_ADDR_I;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= ST_SC_ADDR;
          end
        end
        ST_RK_ADDR_I: state_q <= ST_RK_LOAD_I;
        ST_RK_LOAD_I: begin
          j_q     <= '0;
          state_q <= ST_RK_ADDR_J;
        end
        ST_RK_ADDR_J: state_q <= ST_RK_CMP;
        ST_RK_CMP: begin
          if (j_last) begin
            state_q <= ST_RK_WRITE;
          end else begin
            j_q     <= j_q + CntW'(1);
            state_q <= ST_RK_ADDR_J;
          end
        end
        ST_RK_WRITE: begin
          if (i_last) begin
            i_q     <= '0;
            phase_q <= 1'b0;
            state_q <= ST_FT_RANK;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= ST_RK_ADDR_I;
          end
        end
        ST_FT_RANK: state_q <= ST_FT_DATA;
        ST_FT_DATA: state_q <= ST_FT_USE;
        ST_FT_USE: begin
          if (i_last) begin
            i_q <= '0;
            if (!phase_q) begin
              phase_q <= 1'b1;
              state_q <= ST_FT_RANK;
            end else begin
              state_q <= ST_COLLECT;
            end
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= ST_FT_RANK;
          end
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.score_sel = SEL_I;
    unique case (state_q)
      ST_COLLECT: cmd_o.accept = start_i;
      ST_MM_DATA: begin
        cmd_o.mm_upd   = 1'b1;
        cmd_o.mm_first = (i_q == '0);
      end
      ST_SC_LOAD:   cmd_o.sc_load = 1'b1;
      ST_SC_DIV:    cmd_o.div_step = 1'b1;
      ST_SC_WRITE:  cmd_o.sc_write = 1'b1;
      ST_RK_LOAD_I: cmd_o.rk_load = 1'b1;
      ST_RK_ADDR_J: cmd_o.score_sel = SEL_J;
      ST_RK_CMP: begin
        cmd_o.rk_cmp = 1'b1;
        cmd_o.j_lt_i = (j_q < i_q);
      end
      ST_RK_WRITE:  cmd_o.rk_write = 1'b1;
      ST_FT_DATA: begin
        cmd_o.area_sel_rank = 1'b1;
        cmd_o.score_sel     = SEL_RANK;
      end
      ST_FT_USE: begin
        if (!phase_q) begin
          cmd_o.sp_upd    = 1'b1;
          cmd_o.first_pos = (i_q == '0);
        end else begin
          cmd_o.emit     = 1'b1;
          cmd_o.last     = i_last;
          cmd_o.set_done = i_last;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bagap_dp.sv @@
module bagap_dp
  import bagap_pkg::*;
#(
  parameter int unsigned MaxContours = MaxContoursDef,
  parameter int unsigned CoordBits   = CoordBitsDef,
  localparam int unsigned IdxW  = $clog2(MaxContours),
  localparam int unsigned CntW  = $clog2(MaxContours + 1),
  localparam int unsigned AreaW = 2 * CoordBits + 1,
  localparam int unsigned ProdW = ScaleW + AreaW,
  localparam int unsigned DivW  = ProdW + FracW,
  localparam int unsigned RemW  = AreaW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [ScaleW-1:0]    cfg_data_i,
  input  logic [CoordBits-1:0] point_x_i,
  input  logic [CoordBits-1:0] point_y_i,
  input  logic                 contour_end_i,
  input  logic                 set_end_i,
  input  cmd_t                 cmd_i,
  input  logic [IdxW-1:0]      idx_i_i,
  input  logic [IdxW-1:0]      idx_j_i,
  output logic [CntW-1:0]      count_o,
  output logic                 result_strobe_o,
  output logic [OutIdxW-1:0]   contour_index_o,
  output logic [OutAreaW-1:0]  box_area_o,
  output logic [ScoreW-1:0]    score_value_o,
  output logic                 is_valid_o,
  output logic                 table_overflow_o,
  output logic                 last_result_o
);

  logic [ScaleW-1:0]    scale_q;
  logic [CoordBits-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic [CoordBits-1:0] minx_n, maxx_n, miny_n, maxy_n;
  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic                 close;
  logic [CoordBits:0]   box_w, box_h;
  logic [2*CoordBits+1:0] box_prod;
  logic                 area_we;

  logic [IdxW-1:0]   area_raddr;
  logic [AreaW-1:0]  area_rd;
  logic [IdxW-1:0]   score_raddr;
  logic [ScoreW-1:0] score_rd;
  logic [IdxW-1:0]   rank_rd;

  logic [AreaW-1:0]  amin_q, amax_q, spread;
  logic [ProdW-1:0]  num;
  logic [DivW-1:0]   dvd_q;
  logic [RemW-1:0]   rem_q, rem_sh;
  logic [ScoreW-1:0] quo_q, score_wr;
  logic [ScoreW-1:0] si_q;
  logic [IdxW-1:0]   pos_q;
  logic [AreaW-1:0]  prev_q, best_q, gap;
  logic [IdxW-1:0]   split_q;
  logic              split_en;

  logic                strobe_q;
  logic [OutIdxW-1:0]  oidx_q;
  logic [OutAreaW-1:0] oarea_q;
  logic [ScoreW-1:0]   oscore_q;
  logic                ovalid_q, oovf_q, olast_q;

  assign close  = contour_end_i | set_end_i;
  assign minx_n = (point_x_i < minx_q) ? point_x_i : minx_q;
  assign maxx_n = (point_x_i > maxx_q) ? point_x_i : maxx_q;
  assign miny_n = (point_y_i < miny_q) ? point_y_i : miny_q;
  assign maxy_n = (point_y_i > maxy_q) ? point_y_i : maxy_q;
  assign box_w  = {1'b0, maxx_n} - {1'b0, minx_n} + (CoordBits+1)'(1);
  assign box_h  = {1'b0, maxy_n} - {1'b0, miny_n} + (CoordBits+1)'(1);
  assign box_prod = box_w * box_h;
  assign area_we  = cmd_i.accept && close && (count_q < CntW'(MaxContours));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleReset;
      minx_q   <= '1;
      miny_q   <= '1;
      maxx_q   <= '0;
      maxy_q   <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
      if (cmd_i.accept) begin
        if (close) begin
          minx_q <= '1;
          miny_q <= '1;
          maxx_q <= '0;
          maxy_q <= '0;
          if (area_we) begin
            count_q <= count_q + CntW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
        end else begin
          minx_q <= minx_n;
          miny_q <= miny_n;
          maxx_q <= maxx_n;
          maxy_q <= maxy_n;
        end
      end
      if (cmd_i.set_done) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      strobe_q <= cmd_i.emit;
    end
  end

  assign area_raddr = cmd_i.area_sel_rank ? rank_rd : idx_i_i;

  always_comb begin
    unique case (cmd_i.score_sel)
      SEL_J:    score_raddr = idx_j_i;
      SEL_RANK: score_raddr = rank_rd;
      default:  score_raddr = idx_i_i;
    endcase
  end

  bagap_ram #(.Width(AreaW), .Depth(MaxContours)) u_area_ram (
    .clk_i   (clk_i),
    .we_i    (area_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (box_prod[AreaW-1:0]),
    .raddr_i (area_raddr),
    .rdata_o (area_rd)
  );

  bagap_ram #(.Width(ScoreW), .Depth(MaxContours)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sc_write),
    .waddr_i (idx_i_i),
    .wdata_i (score_wr),
    .raddr_i (score_raddr),
    .rdata_o (score_rd)
  );

  bagap_ram #(.Width(IdxW), .Depth(MaxContours)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rk_write),
    .waddr_i (pos_q),
    .wdata_i (idx_i_i),
    .raddr_i (idx_i_i),
    .rdata_o (rank_rd)
  );

  assign spread   = amax_q - amin_q;
  assign num      = scale_q * (area_rd - amin_q);
  assign rem_sh   = {rem_q[RemW-2:0], dvd_q[DivW-1]};
  assign score_wr = (spread == '0) ? '0 : quo_q;
  assign gap      = prev_q - area_rd;
  assign split_en = (spread != '0) && (scale_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mm_upd) begin
      if (cmd_i.mm_first || area_rd < amin_q) begin
        amin_q <= area_rd;
      end
      if (cmd_i.mm_first || area_rd > amax_q) begin
        amax_q <= area_rd;
      end
    end
    if (cmd_i.sc_load) begin
      dvd_q <= {num, FracW'(0)};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DivW-2:0], 1'b0};
      if (rem_sh >= {1'b0, spread}) begin
        rem_q <= rem_sh - {1'b0, spread};
        quo_q <= {quo_q[ScoreW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[ScoreW-2:0], 1'b0};
      end
    end
    if (cmd_i.rk_load) begin
      si_q  <= score_rd;
      pos_q <= '0;
    end else if (cmd_i.rk_cmp) begin
      if (score_rd > si_q || (score_rd == si_q && cmd_i.j_lt_i)) begin
        pos_q <= pos_q + IdxW'(1);
      end
    end
    if (cmd_i.sp_upd) begin
      prev_q <= area_rd;
      if (cmd_i.first_pos) begin
        best_q  <= '0;
        split_q <= '0;
      end else if (split_en && prev_q > area_rd && gap > best_q) begin
        best_q  <= gap;
        split_q <= idx_i_i;
      end
    end
    if (cmd_i.emit) begin
      oidx_q   <= OutIdxW'(rank_rd);
      oarea_q  <= OutAreaW'(area_rd);
      oscore_q <= score_rd;
      ovalid_q <= idx_i_i < split_q;
      oovf_q   <= ovf_q;
      olast_q  <= cmd_i.last;
    end
  end

  assign count_o          = count_q;
  assign result_strobe_o  = strobe_q;
  assign contour_index_o  = oidx_q;
  assign box_area_o       = oarea_q;
  assign score_value_o    = oscore_q;
  assign is_valid_o       = ovalid_q;
  assign table_overflow_o = oovf_q;
  assign last_result_o    = olast_q;

endmodule

@@ rtl/blob_area_largest_gap_split.sv @@
// Points are taken one a cycle while busy is low; a point with set_end starts the
// ranking of the set, and busy stays high until the last result has gone out. The
// stored contours then pass through a min and max sweep, the bit-serial score divider
// (DivSteps = 2*COORD_BITS+27 shift-subtract steps each), rank counting over the score
// memory, and a split sweep and output pass, all set by the single read port of each
// table. Results come out on single-cycle strobes, one per round of the rank, data and
// use states; the receiver cannot stall them and must take every word as it appears.
module blob_area_largest_gap_split
  import bagap_pkg::*;
#(
  parameter int unsigned MAX_CONTOURS = MaxContoursDef,
  parameter int unsigned COORD_BITS   = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic                  contour_end_i,
  input  logic                  set_end_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ScaleW-1:0]     cfg_data_i,
  output logic                  result_strobe_o,
  output logic [OutIdxW-1:0]    contour_index_o,
  output logic [OutAreaW-1:0]   box_area_o,
  output logic [ScoreW-1:0]     score_value_o,
  output logic                  is_valid_o,
  output logic                  table_overflow_o,
  output logic                  last_result_o
);

  localparam int unsigned IdxW     = $clog2(MAX_CONTOURS);
  localparam int unsigned CntW     = $clog2(MAX_CONTOURS + 1);
  localparam int unsigned DivSteps = ScaleW + 2 * COORD_BITS + 1 + FracW;

  cmd_t            cmd;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] idx_i, idx_j;

  assign cfg_ready_o = 1'b1;

  bagap_ctrl #(.MaxContours(MAX_CONTOURS), .DivSteps(DivSteps)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .set_end_i (set_end_i),
    .count_i   (count),
    .busy_o    (busy),
    .cmd_o     (cmd),
    .idx_i_o   (idx_i),
    .idx_j_o   (idx_j)
  );

  bagap_dp #(.MaxContours(MAX_CONTOURS), .CoordBits(COORD_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .contour_end_i    (contour_end_i),
    .set_end_i        (set_end_i),
    .cmd_i            (cmd),
    .idx_i_i          (idx_i),
    .idx_j_i          (idx_j),
    .count_o          (count),
    .result_strobe_o  (result_strobe_o),
    .contour_index_o  (contour_index_o),
    .box_area_o       (box_area_o),
    .score_value_o    (score_value_o),
    .is_valid_o       (is_valid_o),
    .table_overflow_o (table_overflow_o),
    .last_result_o    (last_result_o)
  );

endmodule
